// ----- sv/mbp_pkg.sv -----
`timescale 1ns / 1ps
package mbp_pkg;

    localparam logic [1:0] REQ_WRITE      = 2'd0;
    localparam logic [1:0] REQ_ALIGN_ZERO = 2'd1;
    localparam logic [1:0] REQ_ALIGN_ONE  = 2'd2;

    localparam int unsigned MAX_FIELD_BITS = 32;
    localparam int unsigned MAX_BYTES      = 4;

    // completed bytes of one request, earliest byte in bits 31:24
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  nbytes;
    } t_job;

endpackage

// ----- sv/msb_first_bit_packer_core.sv -----
`timescale 1ns / 1ps
// MSB-first bit packer. Each request on the slave stream either appends the low
// 1 to 32 bits of a value (a zero length does nothing, lengths above 32 count as
// 32) or pads the held bits to a byte boundary with zeros or ones; padding when
// already aligned does nothing. Up to 7 bits wait between requests. Every byte a
// request completes leaves on the master stream, earliest first, with tlast on
// the final byte of that request, so a request makes 0 to 4 bytes. A request is
// taken every cycle while the request queue (QUEUE_DEPTH entries) has room; the
// output sends one byte per cycle while the receiver is ready, so a request
// producing N bytes holds the output until all N have left, and sustained 32-bit
// writes are limited by the byte-wide output. The fourth request code does nothing.
module msb_first_bit_packer_core
    import mbp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // field_value[31:0], field_length[37:32], zero[39:38]
    input  logic [1:0]  i_s_tuser,  // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // out_byte[7:0]
    output logic        o_m_tlast
);

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    t_job push_job;
    t_job pop_job;
    logic accept;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    mbp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_s_tuser),
        .i_field_value  (i_s_tdata[31:0]),
        .i_field_length (i_s_tdata[37:32]),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_job          (push_job)
    );

    mbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (pop_job),
        .i_pop   (q_pop)
    );

    mbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_job    (pop_job),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- sv/mbp_front.sv -----
`timescale 1ns / 1ps
module mbp_front
    import mbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_field_value,
    input  logic [5:0]  i_field_length,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [6:0]  r_pend;
    logic [2:0]  r_cnt;
    logic [6:0]  n_pend;
    logic [2:0]  n_cnt;

    logic        op_en;
    logic [5:0]  len;
    logic [31:0] val;
    logic [31:0] len_mask;
    logic [38:0] acc;
    logic [5:0]  total;
    logic [2:0]  nb;
    logic [31:0] bytes;
    logic [1:0]  gap;

    always_comb begin
        op_en = 1'b0;
        len   = '0;
        val   = '0;
        case (i_req_type)
            REQ_WRITE: begin
                op_en = (i_field_length != 6'd0);
                len   = (i_field_length > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS)
                                                              : i_field_length;
                val   = i_field_value;
            end
            REQ_ALIGN_ZERO: begin
                op_en = (r_cnt != 3'd0);
                len   = 6'd8 - {3'd0, r_cnt};
                val   = '0;
            end
            REQ_ALIGN_ONE: begin
                op_en = (r_cnt != 3'd0);
                len   = 6'd8 - {3'd0, r_cnt};
                val   = '1;
            end
            default: begin
                op_en = 1'b0;
            end
        endcase

        len_mask = 32'((33'd1 << len) - 33'd1);
        acc      = ({32'd0, r_pend} << len) | {7'd0, val & len_mask};
        total    = len + {3'd0, r_cnt};
        nb       = total[5:3];
        bytes    = 32'(acc >> total[2:0]);
        gap      = 2'(3'(MAX_BYTES) - nb);

        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (i_accept && op_en) begin
            n_cnt  = total[2:0];
            n_pend = acc[6:0] & 7'((8'd1 << total[2:0]) - 8'd1);
        end

        o_push       = i_accept && op_en && (nb != 3'd0);
        o_job.bytes  = bytes << {gap, 3'b000};
        o_job.nbytes = nb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

    a_push_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.nbytes != 3'd0) && (o_job.nbytes <= 3'(MAX_BYTES)))
        else $error("front pushed an empty or oversized request");

    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend >> r_cnt) == 7'd0)
        else $error("pending bits above the held count are not zero");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> !i_queue_full)
        else $error("request accepted while queue is full");

endmodule

// ----- sv/mbp_queue.sv -----
`timescale 1ns / 1ps
module mbp_queue
    import mbp_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    logic          do_push;
    logic          do_pop;

    always_comb begin
        o_full  = (r_cnt == CW'(DEPTH));
        o_valid = (r_cnt != '0);
        o_job   = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ----- sv/mbp_back.sv -----
`timescale 1ns / 1ps
module mbp_back
    import mbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_q_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast
);

    logic [31:0] r_data;
    logic [2:0]  r_left;
    logic [31:0] n_data;
    logic [2:0]  n_left;
    logic        take;

    always_comb begin
        o_m_tvalid = (r_left != 3'd0);
        o_m_tdata  = r_data[31:24];
        o_m_tlast  = (r_left == 3'd1);
        take       = o_m_tvalid && i_m_tready;
        // refill when the output is idle or as the last byte of the current request leaves
        o_q_pop    = i_q_valid && (!o_m_tvalid || (o_m_tlast && take));
        n_data     = r_data;
        n_left     = r_left;
        if (o_q_pop) begin
            n_data = i_q_job.bytes;
            n_left = i_q_job.nbytes;
        end else if (take) begin
            n_data = {r_data[23:0], 8'd0};
            n_left = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'(MAX_BYTES))
        else $error("byte count out of range");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && o_m_tlast && !o_q_pop |=> r_left == 3'd0)
        else $error("output not idle after final byte");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(r_data) && $stable(r_left))
        else $error("output byte changed while stalled");

endmodule

// ----- tb/msb_first_bit_packer_core_tb.sv -----
`timescale 1ns / 1ps
module msb_first_bit_packer_core_tb;
    import mbp_pkg::*;

    // request code the block must ignore
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // field_value[31:0], field_length[37:32], zero[39:38]
    logic [1:0]  i_s_tuser;   // req_type[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // out_byte[7:0]
    logic        o_m_tlast;

    // predictor state: bits still short of a whole byte
    logic [6:0]   held_bits;
    logic [2:0]   held_count;
    t_stream_byte expected_bytes[$];

    int errors;
    bit idle_on;
    int hold_left;

    msb_first_bit_packer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // append the low bits of a field and queue every byte it completes
    task automatic append_field(input logic [31:0] value, input logic [5:0] length);
        logic [63:0] acc;
        logic [63:0] field;
        int          nbits;
        int          total;
        int          keep;
        int          nbytes;
        t_stream_byte b;
        nbits = (length > 6'd32) ? 32 : int'(length);
        if (nbits == 0)
            return;
        field = {32'd0, value} & ((64'd1 << nbits) - 64'd1);
        acc   = ({57'd0, held_bits} & ((64'd1 << held_count) - 64'd1)) << nbits;
        acc   = acc | field;
        total = nbits + int'(held_count);
        keep  = total % 8;
        held_bits  = 7'(acc & ((64'd1 << keep) - 64'd1));
        held_count = 3'(keep);
        acc    = acc >> keep;
        nbytes = total / 8;
        for (int k = 0; k < nbytes; k++) begin
            b.data = 8'(acc >> (8 * (nbytes - 1 - k)));
            b.last = (k == nbytes - 1);
            expected_bytes = {expected_bytes, b};
        end
    endtask

    task automatic predict_request(input logic [1:0] kind, input logic [31:0] value,
                                   input logic [5:0] length);
        int pad;
        case (kind)
            REQ_WRITE: begin
                append_field(value, length);
            end
            REQ_ALIGN_ZERO, REQ_ALIGN_ONE: begin
                if (held_count != 3'd0) begin
                    pad = 8 - int'(held_count);
                    append_field((kind == REQ_ALIGN_ONE) ? ((32'd1 << pad) - 32'd1) : 32'd0,
                                 6'(pad));
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [31:0] value,
                                input logic [5:0] length);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = kind;
        i_s_tdata  = {2'b00, length, value};
        do @(posedge i_clk); while (!o_s_tready);
        predict_request(kind, value, length);
    endtask

    task automatic send_random_request;
        int          pick;
        logic [1:0]  kind;
        logic [5:0]  length;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            kind = REQ_WRITE;
        else if (pick < 80)
            kind = REQ_ALIGN_ZERO;
        else if (pick < 95)
            kind = REQ_ALIGN_ONE;
        else
            kind = REQ_RESERVED;
        // mostly legal lengths, now and then an overlong one
        if ($urandom_range(0, 9) == 0)
            length = 6'($urandom_range(33, 63));
        else
            length = 6'($urandom_range(0, 32));
        send_request(kind, $urandom, length);
    endtask

    // receiver: random stall bursts, plus a long hold-off on demand
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_m_tready = 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    initial begin
        t_stream_byte want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t unexpected byte: expected none, actual %02h last %0b",
                             $time, o_m_tdata, o_m_tlast);
                    errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_m_tdata !== want.data || o_m_tlast !== want.last) begin
                        $display("%0t mismatch: expected %02h last %0b, actual %02h last %0b",
                                 $time, want.data, want.last, o_m_tdata, o_m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed;
        send_request(REQ_WRITE, 32'hFFFF_FFFF, 6'd0);
        send_request(REQ_ALIGN_ZERO, 32'hFFFF_FFFF, 6'd5);   // already aligned
        send_request(REQ_ALIGN_ONE, 32'h0, 6'd0);            // already aligned
        send_request(REQ_WRITE, 32'h0000_0001, 6'd1);
        send_request(REQ_ALIGN_ZERO, 32'hDEAD_BEEF, 6'd17);
        send_request(REQ_WRITE, 32'hFFFF_FFFF, 6'd32);
        send_request(REQ_WRITE, 32'h0000_0000, 6'd32);
        send_request(REQ_WRITE, 32'hAAAA_AAAA, 6'd32);
        send_request(REQ_WRITE, 32'h5555_5555, 6'd32);
        send_request(REQ_WRITE, 32'hFFFF_FFFF, 6'd5);        // upper bits masked
        send_request(REQ_ALIGN_ONE, 32'h0, 6'd0);
        send_request(REQ_WRITE, 32'h1234_5678, 6'd63);       // overlong, counts as 32
        send_request(REQ_WRITE, 32'h8765_4321, 6'd33);
        send_request(REQ_WRITE, 32'h0000_007F, 6'd7);
        send_request(REQ_RESERVED, 32'hFFFF_FFFF, 6'd63);    // ignored
        send_request(REQ_ALIGN_ONE, 32'hFFFF_FFFF, 6'd32);
        send_request(REQ_WRITE, 32'h0000_00A5, 6'd8);
        send_request(REQ_WRITE, 32'h0000_C3C3, 6'd16);
        send_request(REQ_WRITE, 32'h00F0_0F0F, 6'd24);
        send_request(REQ_WRITE, 32'h0000_0003, 6'd3);
        send_request(REQ_ALIGN_ZERO, 32'h0, 6'd0);
        send_request(REQ_WRITE, 32'h0000_0000, 6'd31);
        send_request(REQ_ALIGN_ONE, 32'h0, 6'd0);
    endtask

    // output held off while full-width writes keep coming
    task automatic test_output_backpressure;
        hold_left = 80;
        for (int i = 0; i < 12; i++)
            send_request(REQ_WRITE, $urandom, 6'd32);
    endtask

    task automatic test_random_mix;
        for (int i = 0; i < 40; i++)
            send_random_request();
    endtask

    task automatic test_full_rate;
        idle_on = 1'b0;
        for (int i = 0; i < 30; i++)
            send_random_request();
    endtask

    initial begin
        errors     = 0;
        idle_on    = 1'b1;
        hold_left  = 0;
        held_bits  = '0;
        held_count = '0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = REQ_WRITE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_output_backpressure();
        test_random_mix();
        test_full_rate();

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- msb_first_bit_packer_core.f -----
sv/mbp_pkg.sv
sv/mbp_front.sv
sv/mbp_queue.sv
sv/mbp_back.sv
sv/msb_first_bit_packer_core.sv
tb/msb_first_bit_packer_core_tb.sv
